FILE: sv/acep_pkg.sv
// acep_pkg: shared constants, types and lookup functions of the ANSI CSI parser.
// No dependencies; the design files refer to it by scoped names, and the bench imports it.
package acep_pkg;

    localparam int MAX_ARGS_DEF  = 8;
    localparam int ARG_WIDTH_DEF = 16;

    localparam int CHAR_W    = 8;
    localparam int CMD_W     = 4;
    localparam int FIELD_W   = 16;
    localparam int RGB_W     = 24;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_BG = 2'd1;

    localparam logic [RGB_W-1:0] DEF_FG_RESET = 24'hAAAAAA;
    localparam logic [RGB_W-1:0] DEF_BG_RESET = 24'h000000;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBR   = 8'h5B;   // '['
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;   // ';'
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;   // '9'
    localparam logic [CHAR_W-1:0] CH_UP    = 8'h41;   // 'A'
    localparam logic [CHAR_W-1:0] CH_DOWN  = 8'h42;   // 'B'
    localparam logic [CHAR_W-1:0] CH_FWD   = 8'h43;   // 'C'
    localparam logic [CHAR_W-1:0] CH_BACK  = 8'h44;   // 'D'
    localparam logic [CHAR_W-1:0] CH_POS   = 8'h48;   // 'H'
    localparam logic [CHAR_W-1:0] CH_POS_F = 8'h66;   // 'f'
    localparam logic [CHAR_W-1:0] CH_ED    = 8'h4A;   // 'J'
    localparam logic [CHAR_W-1:0] CH_EL    = 8'h4B;   // 'K'
    localparam logic [CHAR_W-1:0] CH_SGR   = 8'h6D;   // 'm'

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT    = 4'd0,
        CMD_UP       = 4'd1,
        CMD_DOWN     = 4'd2,
        CMD_FORWARD  = 4'd3,
        CMD_BACK     = 4'd4,
        CMD_POSITION = 4'd5,
        CMD_ERASE_D  = 4'd6,
        CMD_ERASE_L  = 4'd7,
        CMD_COLORS   = 4'd8
    } cmd_t;

    typedef struct packed {
        logic known;
        cmd_t kind;
    } final_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_byte;
        logic param_clear;
        logic param_digit;
        logic param_semi;
        logic param_commit;
        logic color_reset;
        logic walk_start;
        logic walk_step;
        logic emit_load;
        logic emit_print;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_esc;
        logic is_lbr;
        logic is_digit;
        logic is_semi;
        logic final_known;
        logic final_colors;
        logic total_zero;
        logic walk_last;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        cmd_t                command;
        logic [CHAR_W-1:0]   char_out;
        logic [FIELD_W-1:0]  move_count;
        logic [FIELD_W-1:0]  target_row;
        logic [FIELD_W-1:0]  target_col;
        logic [FIELD_W-1:0]  erase_mode;
        logic [RGB_W-1:0]    fg_color;
        logic [RGB_W-1:0]    bg_color;
    } result_t;

    function automatic final_t final_decode(input logic [CHAR_W-1:0] c);
        final_t f;
        f.known = 1'b1;
        f.kind  = CMD_PRINT;
        unique case (c)
            CH_UP:            f.kind = CMD_UP;
            CH_DOWN:          f.kind = CMD_DOWN;
            CH_FWD:           f.kind = CMD_FORWARD;
            CH_BACK:          f.kind = CMD_BACK;
            CH_POS, CH_POS_F: f.kind = CMD_POSITION;
            CH_ED:            f.kind = CMD_ERASE_D;
            CH_EL:            f.kind = CMD_ERASE_L;
            CH_SGR:           f.kind = CMD_COLORS;
            default:          f.known = 1'b0;
        endcase
        return f;
    endfunction

    function automatic logic [RGB_W-1:0] pal_normal(input logic [2:0] i);
        logic [RGB_W-1:0] rgb;
        case (i)
            3'd0:    rgb = 24'h000000;
            3'd1:    rgb = 24'hAA0000;
            3'd2:    rgb = 24'h00AA00;
            3'd3:    rgb = 24'hAA5500;
            3'd4:    rgb = 24'h0000AA;
            3'd5:    rgb = 24'hAA00AA;
            3'd6:    rgb = 24'h00AAAA;
            default: rgb = 24'hAAAAAA;
        endcase
        return rgb;
    endfunction

    function automatic logic [RGB_W-1:0] pal_bright(input logic [2:0] i);
        logic [RGB_W-1:0] rgb;
        case (i)
            3'd0:    rgb = 24'h555555;
            3'd1:    rgb = 24'hFF5555;
            3'd2:    rgb = 24'h55FF55;
            3'd3:    rgb = 24'hFFFF55;
            3'd4:    rgb = 24'h5555FF;
            3'd5:    rgb = 24'hFF55FF;
            3'd6:    rgb = 24'h55FFFF;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

FILE: sv/acep_byte_if.sv
// acep_byte_if: valid/ready channel carrying one terminal byte per request.
// Depends on acep_pkg for the byte width.
interface acep_byte_if;
    logic                        valid;
    logic                        ready;
    logic [acep_pkg::CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

FILE: sv/acep_result_if.sv
// acep_result_if: valid/ready channel carrying one console command per request.
// Depends on acep_pkg for the field widths.
interface acep_result_if;
    logic                         valid;
    logic                         ready;
    logic [acep_pkg::CMD_W-1:0]   command;
    logic [acep_pkg::CHAR_W-1:0]  char_out;
    logic [acep_pkg::FIELD_W-1:0] move_count;
    logic [acep_pkg::FIELD_W-1:0] target_row;
    logic [acep_pkg::FIELD_W-1:0] target_col;
    logic [acep_pkg::FIELD_W-1:0] erase_mode;
    logic [acep_pkg::RGB_W-1:0]   fg_color;
    logic [acep_pkg::RGB_W-1:0]   bg_color;

    modport source (output valid, output command, output char_out, output move_count,
                    output target_row, output target_col, output erase_mode,
                    output fg_color, output bg_color, input ready);
    modport sink   (input valid, input command, input char_out, input move_count,
                    input target_row, input target_col, input erase_mode,
                    input fg_color, input bg_color, output ready);
endinterface

FILE: sv/acep_cfg_if.sv
// acep_cfg_if: configuration write channel (register index and write data).
// Depends on acep_pkg for the index and data widths.
interface acep_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [acep_pkg::CFG_IDX_W-1:0] index;
    logic [acep_pkg::RGB_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/acep_ctrl.sv
// acep_ctrl: controller FSM of the parser; tracks the escape phase and sequences
// parse, decode, SGR walk and emit. Depends on acep_pkg (command/status structs).
module acep_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output acep_pkg::dp_cmd_t    cmd,
    input  acep_pkg::dp_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PARSE  = 5'b00010,
        ST_DECODE = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_ESC    = 3'b010,
        PH_CSI    = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   print_reg, print_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NORMAL;
            print_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            print_reg <= print_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        print_next = print_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_byte = in_valid;
                if (in_valid)
                begin
                    state_next = ST_PARSE;
                end
            end
            ST_PARSE:
            begin
                state_next = ST_IDLE;
                print_next = 1'b0;
                unique case (phase_reg)
                    PH_NORMAL:
                    begin
                        if (status.is_esc)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            print_next = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    PH_ESC:
                    begin
                        if (status.is_lbr)
                        begin
                            cmd.param_clear = 1'b1;
                            phase_next      = PH_CSI;
                        end
                        else
                        begin
                            phase_next = PH_NORMAL;
                        end
                    end
                    PH_CSI:
                    begin
                        if (status.is_digit)
                        begin
                            cmd.param_digit = 1'b1;
                        end
                        else if (status.is_semi)
                        begin
                            cmd.param_semi = 1'b1;
                        end
                        else
                        begin
                            cmd.param_commit = 1'b1;
                            phase_next       = PH_NORMAL;
                            if (status.final_known)
                            begin
                                state_next = ST_DECODE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_NORMAL;
                    end
                endcase
            end
            ST_DECODE:
            begin
                state_next = ST_EMIT;
                if (status.final_colors)
                begin
                    if (status.total_zero)
                    begin
                        cmd.color_reset = 1'b1;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_print = print_reg;
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/acep_datapath.sv
// acep_datapath: byte register, parameter accumulator and registers, color state,
// default color registers and output register. Depends on acep_pkg.
module acep_datapath #(
    parameter int MAX_ARGS  = acep_pkg::MAX_ARGS_DEF,
    parameter int ARG_WIDTH = acep_pkg::ARG_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  acep_pkg::dp_cmd_t              cmd,
    output acep_pkg::dp_status_t           status,
    input  logic [acep_pkg::CHAR_W-1:0]    char_in,
    input  logic                           cfg_we,
    input  logic [acep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [acep_pkg::RGB_W-1:0]     cfg_wdata,
    input  logic                           out_ready,
    output logic                           out_valid,
    output acep_pkg::result_t              result
);

    localparam int TW        = $clog2(MAX_ARGS + 1);
    localparam int IW        = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int SemiFirst = (MAX_ARGS >= 2) ? 2 : 1;
    localparam int SecIdx    = (MAX_ARGS >= 2) ? 1 : 0;
    localparam int AWX       = ARG_WIDTH + 4;

    logic [acep_pkg::CHAR_W-1:0] byte_reg;
    logic [ARG_WIDTH-1:0]        acc_reg, acc_next;
    logic [ARG_WIDTH-1:0]        slot_reg [MAX_ARGS];
    logic [TW-1:0]               total_reg, total_next;
    logic [IW-1:0]               walk_reg, walk_next;
    logic [acep_pkg::RGB_W-1:0]  def_fg_reg, def_bg_reg;
    logic [acep_pkg::RGB_W-1:0]  fg_reg, fg_next, bg_reg, bg_next;
    logic                        bold_reg, bold_next;
    logic                        out_valid_reg;
    acep_pkg::result_t           result_reg, result_next;

    acep_pkg::final_t     fin;
    logic [3:0]           digit;
    logic [AWX-1:0]       acc_wide;
    logic [ARG_WIDTH-1:0] acc_sat;
    logic [TW-1:0]        total_m1;
    logic                 total_zero;
    logic                 semi_takes;
    logic                 slot_we;
    logic [IW-1:0]        slot_widx;
    logic [ARG_WIDTH-1:0] sgr_p;
    logic [ARG_WIDTH-1:0] off30, off40, off90, off100;
    logic [ARG_WIDTH-1:0] a0, a1, a0_eff, a1_eff;
    logic                 a0_ok, a1_ok;

    // ---------------- classification ----------------
    assign fin        = acep_pkg::final_decode(byte_reg);
    assign digit      = 4'(byte_reg - acep_pkg::CH_ZERO);
    assign total_zero = (total_reg == '0);
    assign total_m1   = total_reg - TW'(1);

    assign status.is_esc       = (byte_reg == acep_pkg::CH_ESC);
    assign status.is_lbr       = (byte_reg == acep_pkg::CH_LBR);
    assign status.is_digit     = (byte_reg >= acep_pkg::CH_ZERO) &&
                                 (byte_reg <= acep_pkg::CH_NINE);
    assign status.is_semi      = (byte_reg == acep_pkg::CH_SEMI);
    assign status.final_known  = fin.known;
    assign status.final_colors = (fin.kind == acep_pkg::CMD_COLORS);
    assign status.total_zero   = total_zero;
    assign status.walk_last    = ((32'(walk_reg) + 32'd1) == 32'(total_reg));
    assign status.out_free     = !out_valid_reg || out_ready;

    // ---------------- parameter accumulation ----------------
    // acc * 10 + digit, saturating at the top of the argument range
    assign acc_wide = (AWX'(acc_reg) << 3) + (AWX'(acc_reg) << 1) + AWX'(digit);
    assign acc_sat  = (|acc_wide[AWX-1:ARG_WIDTH]) ? '1 : acc_wide[ARG_WIDTH-1:0];

    assign semi_takes = total_zero || (32'(total_reg) < MAX_ARGS);
    assign slot_we    = (cmd.param_semi && semi_takes) || (cmd.param_commit && !total_zero);
    assign slot_widx  = total_zero ? '0 : total_m1[IW-1:0];

    always_comb
    begin
        acc_next   = acc_reg;
        total_next = total_reg;
        if (cmd.param_clear)
        begin
            acc_next   = '0;
            total_next = '0;
        end
        else if (cmd.param_digit)
        begin
            acc_next = acc_sat;
            if (total_zero)
            begin
                total_next = TW'(1);
            end
        end
        else if (cmd.param_semi && semi_takes)
        begin
            acc_next   = '0;
            total_next = total_zero ? TW'(SemiFirst) : total_reg + TW'(1);
        end
    end

    always_comb
    begin
        walk_next = walk_reg;
        if (cmd.walk_start)
        begin
            walk_next = '0;
        end
        else if (cmd.walk_step)
        begin
            walk_next = walk_reg + IW'(1);
        end
    end

    // ---------------- SGR walk ----------------
    assign sgr_p  = slot_reg[walk_reg];
    assign off30  = sgr_p - ARG_WIDTH'(30);
    assign off40  = sgr_p - ARG_WIDTH'(40);
    assign off90  = sgr_p - ARG_WIDTH'(90);
    assign off100 = sgr_p - ARG_WIDTH'(100);

    always_comb
    begin
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        bold_next = bold_reg;
        if (cmd.color_reset)
        begin
            fg_next   = def_fg_reg;
            bg_next   = def_bg_reg;
            bold_next = 1'b0;
        end
        else if (cmd.walk_step)
        begin
            if (sgr_p == '0)
            begin
                fg_next   = def_fg_reg;
                bg_next   = def_bg_reg;
                bold_next = 1'b0;
            end
            else if (sgr_p == ARG_WIDTH'(1))
            begin
                bold_next = 1'b1;
            end
            else if (sgr_p >= ARG_WIDTH'(30) && sgr_p <= ARG_WIDTH'(37))
            begin
                fg_next = bold_reg ? acep_pkg::pal_bright(off30[2:0])
                                   : acep_pkg::pal_normal(off30[2:0]);
            end
            else if (sgr_p == ARG_WIDTH'(39))
            begin
                fg_next = def_fg_reg;
            end
            else if (sgr_p >= ARG_WIDTH'(40) && sgr_p <= ARG_WIDTH'(47))
            begin
                bg_next = acep_pkg::pal_normal(off40[2:0]);
            end
            else if (sgr_p == ARG_WIDTH'(49))
            begin
                bg_next = def_bg_reg;
            end
            else if (sgr_p >= ARG_WIDTH'(90) && sgr_p <= ARG_WIDTH'(97))
            begin
                fg_next = acep_pkg::pal_bright(off90[2:0]);
            end
            else if (sgr_p >= ARG_WIDTH'(100) && sgr_p <= ARG_WIDTH'(107))
            begin
                bg_next = acep_pkg::pal_bright(off100[2:0]);
            end
        end
    end

    // ---------------- result assembly ----------------
    assign a0     = slot_reg[0];
    assign a1     = slot_reg[SecIdx];
    assign a0_ok  = !total_zero && (a0 != '0);
    assign a1_ok  = (MAX_ARGS >= 2) && (32'(total_reg) >= 32'd2) && (a1 != '0);
    assign a0_eff = a0_ok ? a0 : ARG_WIDTH'(1);
    assign a1_eff = a1_ok ? a1 : ARG_WIDTH'(1);

    always_comb
    begin
        result_next          = '0;
        result_next.fg_color = fg_reg;
        result_next.bg_color = bg_reg;
        if (cmd.emit_print)
        begin
            result_next.command  = acep_pkg::CMD_PRINT;
            result_next.char_out = byte_reg;
        end
        else
        begin
            result_next.command = fin.kind;
            case (fin.kind)
                acep_pkg::CMD_UP, acep_pkg::CMD_DOWN,
                acep_pkg::CMD_FORWARD, acep_pkg::CMD_BACK:
                begin
                    result_next.move_count = acep_pkg::FIELD_W'(a0_eff);
                end
                acep_pkg::CMD_POSITION:
                begin
                    result_next.target_row = acep_pkg::FIELD_W'(a0_eff - ARG_WIDTH'(1));
                    result_next.target_col = acep_pkg::FIELD_W'(a1_eff - ARG_WIDTH'(1));
                end
                acep_pkg::CMD_ERASE_D, acep_pkg::CMD_ERASE_L:
                begin
                    result_next.erase_mode = a0_ok ? acep_pkg::FIELD_W'(a0) : '0;
                end
                default:
                begin
                    result_next.move_count = '0;
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            total_reg     <= '0;
            walk_reg      <= '0;
            def_fg_reg    <= acep_pkg::DEF_FG_RESET;
            def_bg_reg    <= acep_pkg::DEF_BG_RESET;
            fg_reg        <= acep_pkg::DEF_FG_RESET;
            bg_reg        <= acep_pkg::DEF_BG_RESET;
            bold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            total_reg <= total_next;
            walk_reg  <= walk_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            bold_reg  <= bold_next;
            if (cfg_we && cfg_index == acep_pkg::CFG_DEF_FG)
            begin
                def_fg_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == acep_pkg::CFG_DEF_BG)
            begin
                def_bg_reg <= cfg_wdata;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_byte)
        begin
            byte_reg <= char_in;
        end
        if (slot_we)
        begin
            slot_reg[slot_widx] <= acc_reg;
        end
        if (cmd.emit_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

FILE: sv/ansi_csi_escape_parser_top.sv
// ansi_csi_escape_parser_top: top level of the ANSI CSI escape parser with SGR colors.
// Depends on acep_pkg, the three channel interfaces, acep_ctrl and acep_datapath.
//
//   channel  modport  request
//   -------  -------  -------------------------------------------------------------
//   bytes    sink     char_in: one byte of the terminal stream
//   actions  source   command, char_out, move_count, target_row/col, erase_mode, colors
//   cfg      sink     index 0 default foreground, index 1 default background
//
// Each byte is latched and parsed; ESC, '[', digits, ';' and anything dropped stop there.
// A printed byte then goes to emit, a cursor, position or erase final to decode and emit,
// an SGR final to decode, a walk of one parameter register per cycle (if any), and emit.
// Reset (rst_n low, asynchronous) returns the parser to normal text, clears the
// parameter count and loads default colors; no clearing pass is needed.
// A stalled result sits in the output register; the next byte is still taken, and
// the parser waits in its emit step only if that byte yields a result too.
// Configuration writes are always accepted.
module ansi_csi_escape_parser_top #(
    parameter int MAX_ARGS  = acep_pkg::MAX_ARGS_DEF,
    parameter int ARG_WIDTH = acep_pkg::ARG_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    acep_byte_if.sink    bytes,
    acep_result_if.source actions,
    acep_cfg_if.sink     cfg
);

    acep_pkg::dp_cmd_t    dp_cmd;
    acep_pkg::dp_status_t dp_status;
    acep_pkg::result_t    result;
    logic                 in_ready;
    logic                 out_valid;

    // FSM: escape phase and step sequencing
    acep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_ready (in_ready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    // parameters, colors, output register
    acep_datapath #(
        .MAX_ARGS  (MAX_ARGS),
        .ARG_WIDTH (ARG_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .char_in   (bytes.char_in),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_wdata (cfg.wdata),
        .out_ready (actions.ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign bytes.ready = in_ready;
    assign cfg.ready   = 1'b1;

    assign actions.valid      = out_valid;
    assign actions.command    = result.command;
    assign actions.char_out   = result.char_out;
    assign actions.move_count = result.move_count;
    assign actions.target_row = result.target_row;
    assign actions.target_col = result.target_col;
    assign actions.erase_mode = result.erase_mode;
    assign actions.fg_color   = result.fg_color;
    assign actions.bg_color   = result.bg_color;

endmodule

FILE: sv/acep_checker.sv
// acep_checker: port-level assertions for the ANSI CSI parser, bound to the top level.
// Depends on acep_pkg and ansi_csi_escape_parser_top.
module acep_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [acep_pkg::CMD_W-1:0]    command,
    input logic [acep_pkg::CHAR_W-1:0]   char_out,
    input logic [acep_pkg::RGB_W-1:0]    fg_color
);

    // stalled request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command) &&
                                    $stable(char_out) && $stable(fg_color))
        else $error("stalled result changed");

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> command <= acep_pkg::CMD_COLORS)
        else $error("command code out of range");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != acep_pkg::CMD_PRINT |-> char_out == '0)
        else $error("char_out set on a non-print command");

    // ready drops once a byte is accepted, while that byte is parsed
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held across an accepted byte");

    // a new result is only loaded while the byte side is busy
    a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while input was idle");

endmodule

bind ansi_csi_escape_parser_top acep_checker u_acep_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bytes.valid),
    .in_ready  (bytes.ready),
    .out_valid (actions.valid),
    .out_ready (actions.ready),
    .command   (actions.command),
    .char_out  (actions.char_out),
    .fg_color  (actions.fg_color)
);

FILE: tb/tb.sv
// tb: self-checking bench for the ANSI CSI escape parser (ansi_csi_escape_parser_top).
// Depends on acep_pkg and the byte, result and configuration channel interfaces.
// A byte-level predictor tracks parser and color state, and each command is checked field by field.
module tb;
    import acep_pkg::*;

    // Unused configuration indexes: writes to them must leave both defaults alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // SGR codes the color list understands.
    localparam int unsigned SGR_RESET      = 0;
    localparam int unsigned SGR_BOLD       = 1;
    localparam int unsigned SGR_FG_BASE    = 30;
    localparam int unsigned SGR_FG_DEFAULT = 39;
    localparam int unsigned SGR_BG_BASE    = 40;
    localparam int unsigned SGR_BG_DEFAULT = 49;
    localparam int unsigned SGR_FG_BRIGHT  = 90;
    localparam int unsigned SGR_BG_BRIGHT  = 100;

    localparam int unsigned ARG_LIMIT     = (1 << ARG_WIDTH_DEF) - 1;
    localparam int          SETTLE_CYCLES = 16;     // SGR walk over 8 args plus margin
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          PRINT_CAP     = 40;

    // Palettes packed low entry first: entry i sits at [i*24 +: 24].
    localparam logic [8*RGB_W-1:0] NORMAL_RGB = {
        24'hAAAAAA, 24'h00AAAA, 24'hAA00AA, 24'h0000AA,
        24'hAA5500, 24'h00AA00, 24'hAA0000, 24'h000000};
    localparam logic [8*RGB_W-1:0] BRIGHT_RGB = {
        24'hFFFFFF, 24'h55FFFF, 24'hFF55FF, 24'h5555FF,
        24'hFFFF55, 24'h55FF55, 24'hFF5555, 24'h555555};

    typedef enum logic [1:0] {PH_TEXT, PH_ESCAPE, PH_CONTROL} scan_phase_t;

    logic clk;
    logic rst_n;

    acep_byte_if   byte_ch ();
    acep_result_if act_ch ();
    acep_cfg_if    cfg_ch ();

    ansi_csi_escape_parser_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .actions (act_ch),
        .cfg     (cfg_ch)
    );

    // ---------------------------------------------------------------
    // Predictor state: parser phase, argument registers, colors.
    // ---------------------------------------------------------------
    scan_phase_t       phase;
    int unsigned       arg_val [MAX_ARGS_DEF];
    int unsigned       arg_count;
    logic [RGB_W-1:0]  dflt_fg;
    logic [RGB_W-1:0]  dflt_bg;
    logic [RGB_W-1:0]  fg_now;
    logic [RGB_W-1:0]  bg_now;
    bit                bold_on;

    result_t           pending_actions [$];    // commands still owed by the parser

    bit                idle_on = 1'b1;         // random gaps and stalls allowed
    int                stall_left = 0;
    int                sent_bytes = 0;
    int                checked_count = 0;
    int                reg_writes = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;

    // ---------------------------------------------------------------
    // Clock, watchdog
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well above the slowest legal run (every byte gapped, every command stalled).
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d commands still owed",
                 cycle_count, pending_actions.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    // First/second argument with its default; zero counts as absent.
    function automatic logic [FIELD_W-1:0] arg_or(input int unsigned idx,
                                                  input int unsigned dflt);
        int unsigned v;
        v = dflt;
        if (idx < arg_count && arg_val[idx] > 0)
            v = arg_val[idx];
        return v[FIELD_W-1:0];
    endfunction

    task automatic restore_colors();
        fg_now  = dflt_fg;
        bg_now  = dflt_bg;
        bold_on = 1'b0;
    endtask

    task automatic reset_predictor();
        int i;
        dflt_fg   = DEF_FG_RESET;
        dflt_bg   = DEF_BG_RESET;
        phase     = PH_TEXT;
        arg_count = 0;
        for (i = 0; i < MAX_ARGS_DEF; i++)
            arg_val[i] = 0;
        restore_colors();
    endtask

    // Walk the SGR list in order; an empty list behaves like a reset.
    task automatic apply_color_list();
        int unsigned p;
        int          i;
        if (arg_count == 0)
            restore_colors();
        for (i = 0; i < arg_count; i++)
        begin
            p = arg_val[i];
            if (p == SGR_RESET)
                restore_colors();
            else if (p == SGR_BOLD)
                bold_on = 1'b1;
            else if (p >= SGR_FG_BASE && p <= SGR_FG_BASE + 7)
                fg_now = bold_on ? BRIGHT_RGB[(p - SGR_FG_BASE)*RGB_W +: RGB_W]
                                 : NORMAL_RGB[(p - SGR_FG_BASE)*RGB_W +: RGB_W];
            else if (p == SGR_FG_DEFAULT)
                fg_now = dflt_fg;
            else if (p >= SGR_BG_BASE && p <= SGR_BG_BASE + 7)
                bg_now = NORMAL_RGB[(p - SGR_BG_BASE)*RGB_W +: RGB_W];
            else if (p == SGR_BG_DEFAULT)
                bg_now = dflt_bg;
            else if (p >= SGR_FG_BRIGHT && p <= SGR_FG_BRIGHT + 7)
                fg_now = BRIGHT_RGB[(p - SGR_FG_BRIGHT)*RGB_W +: RGB_W];
            else if (p >= SGR_BG_BRIGHT && p <= SGR_BG_BRIGHT + 7)
                bg_now = BRIGHT_RGB[(p - SGR_BG_BRIGHT)*RGB_W +: RGB_W];
            // anything else is skipped
        end
    endtask

    // One accepted byte: advance the parser and queue the command it yields, if any.
    task automatic track_terminal_byte(input logic [CHAR_W-1:0] c);
        result_t     act;
        bit          emit;
        int unsigned v;
        int          i;
        act  = '0;
        emit = 1'b0;
        case (phase)
            PH_TEXT:
            begin
                if (c == CH_ESC)
                    phase = PH_ESCAPE;
                else
                begin
                    act.command  = CMD_PRINT;
                    act.char_out = c;
                    emit         = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                // anything but '[' drops the escape
                if (c == CH_LBR)
                begin
                    phase     = PH_CONTROL;
                    arg_count = 0;
                    for (i = 0; i < MAX_ARGS_DEF; i++)
                        arg_val[i] = 0;
                end
                else
                    phase = PH_TEXT;
            end
            default:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    if (arg_count == 0)
                        arg_count = 1;
                    v = arg_val[arg_count-1] * 10 + (c - CH_ZERO);
                    arg_val[arg_count-1] = (v > ARG_LIMIT) ? ARG_LIMIT : v;
                end
                else if (c == CH_SEMI)
                begin
                    // leading ';' opens an empty first arg; past the last slot it is dropped
                    if (arg_count == 0)
                        arg_count = 2;
                    else if (arg_count < MAX_ARGS_DEF)
                        arg_count++;
                end
                else
                begin
                    phase = PH_TEXT;
                    emit  = 1'b1;
                    case (c)
                        CH_UP:
                        begin
                            act.command    = CMD_UP;
                            act.move_count = arg_or(0, 1);
                        end
                        CH_DOWN:
                        begin
                            act.command    = CMD_DOWN;
                            act.move_count = arg_or(0, 1);
                        end
                        CH_FWD:
                        begin
                            act.command    = CMD_FORWARD;
                            act.move_count = arg_or(0, 1);
                        end
                        CH_BACK:
                        begin
                            act.command    = CMD_BACK;
                            act.move_count = arg_or(0, 1);
                        end
                        CH_POS, CH_POS_F:
                        begin
                            act.command    = CMD_POSITION;
                            act.target_row = arg_or(0, 1) - 1'b1;
                            act.target_col = arg_or(1, 1) - 1'b1;
                        end
                        CH_ED:
                        begin
                            act.command    = CMD_ERASE_D;
                            act.erase_mode = arg_or(0, 0);
                        end
                        CH_EL:
                        begin
                            act.command    = CMD_ERASE_L;
                            act.erase_mode = arg_or(0, 0);
                        end
                        CH_SGR:
                        begin
                            act.command = CMD_COLORS;
                            apply_color_list();
                        end
                        default: emit = 1'b0;   // unknown final, ESC included
                    endcase
                end
            end
        endcase
        if (emit)
        begin
            act.fg_color = fg_now;
            act.bg_color = bg_now;
            pending_actions.push_back(act);
        end
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d, %s: got %h, expected %h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_action();
        result_t want;
        if (pending_actions.size() == 0)
        begin
            report_mismatch("command with nothing owed", act_ch.command, '0);
            return;
        end
        want = pending_actions.pop_front();
        checked_count++;
        if (act_ch.command !== want.command)
            report_mismatch("command", act_ch.command, want.command);
        if (act_ch.char_out !== want.char_out)
            report_mismatch("char_out", act_ch.char_out, want.char_out);
        if (act_ch.move_count !== want.move_count)
            report_mismatch("move_count", act_ch.move_count, want.move_count);
        if (act_ch.target_row !== want.target_row)
            report_mismatch("target_row", act_ch.target_row, want.target_row);
        if (act_ch.target_col !== want.target_col)
            report_mismatch("target_col", act_ch.target_col, want.target_col);
        if (act_ch.erase_mode !== want.erase_mode)
            report_mismatch("erase_mode", act_ch.erase_mode, want.erase_mode);
        if (act_ch.fg_color !== want.fg_color)
            report_mismatch("fg_color", act_ch.fg_color, want.fg_color);
        if (act_ch.bg_color !== want.bg_color)
            report_mismatch("bg_color", act_ch.bg_color, want.bg_color);
    endtask

    // Console side: random stall bursts while idling is on.
    initial
    begin
        act_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && act_ch.valid && act_ch.ready)
                check_action();
            if (stall_left > 0)
            begin
                stall_left--;
                act_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                act_ch.ready <= 1'b0;
            end
            else
                act_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Byte and register drivers
    // ---------------------------------------------------------------
    // Present one byte, wait for the request to be taken, then predict it.
    // valid stays high after acceptance so back-to-back bytes need no toggle.
    task automatic send_byte(input logic [CHAR_W-1:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.char_in <= c;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        track_terminal_byte(c);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // ESC '[' followed by the body text.
    task automatic send_seq(input string body);
        send_byte(CH_ESC);
        send_byte(CH_LBR);
        send_text(body);
    endtask

    task automatic send_decimal(input int unsigned v, input int lead_zeros);
        logic [3:0] digs [0:9];
        int         n;
        int         i;
        n = 0;
        do
        begin
            digs[n] = 4'(v % 10);
            v       = v / 10;
            n++;
        end
        while (v != 0);
        repeat (lead_zeros) send_byte(CH_ZERO);
        for (i = n - 1; i >= 0; i--)
            send_byte(CH_ZERO + digs[i]);
    endtask

    // Byte channel quiet, every command delivered, and the last dropped
    // byte given time to leave the pipeline.
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RGB_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_DEF_FG)
            dflt_fg = data;
        else if (idx == CFG_DEF_BG)
            dflt_bg = data;
        reg_writes++;
    endtask

    // Load both defaults while the parser is idle; optionally poke an unused index.
    task automatic write_defaults(input logic [RGB_W-1:0] fg, input logic [RGB_W-1:0] bg,
                                  input bit spare);
        wait_idle();
        put_reg(CFG_DEF_FG, fg);
        put_reg(CFG_DEF_BG, bg);
        if (spare)
            put_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, RGB_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Random generators
    // ---------------------------------------------------------------
    function automatic logic [RGB_W-1:0] pick_rgb();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return RGB_W'($urandom);
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_final();
        case ($urandom_range(0, 11))
            0:       return CH_UP;
            1:       return CH_DOWN;
            2:       return CH_FWD;
            3:       return CH_BACK;
            4:       return CH_POS;
            5:       return CH_POS_F;
            6:       return CH_ED;
            7:       return CH_EL;
            default: return CH_SGR;
        endcase
    endfunction

    function automatic int unsigned pick_sgr();
        case ($urandom_range(0, 7))
            0:       return SGR_RESET;
            1:       return SGR_BOLD;
            2:       return SGR_FG_BASE + $urandom_range(0, 7);
            3:       return SGR_BG_BASE + $urandom_range(0, 7);
            4:       return SGR_FG_BRIGHT + $urandom_range(0, 7);
            5:       return SGR_BG_BRIGHT + $urandom_range(0, 7);
            6:       return $urandom_range(0, 1) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    // One control sequence with random arguments. known=0 ends it with ESC or a
    // random non-digit, non-';' byte, which may itself be a command letter.
    task automatic send_random_csi(input bit known);
        logic [CHAR_W-1:0] fin;
        int                n;
        int                i;
        int                r;
        if (known)
            fin = pick_final();
        else if ($urandom_range(0, 3) == 0)
            fin = CH_ESC;
        else
        begin
            do
                fin = CHAR_W'($urandom_range(0, 255));
            while ((fin >= CH_ZERO && fin <= CH_NINE) || fin == CH_SEMI);
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 3);
        send_byte(CH_ESC);
        send_byte(CH_LBR);
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
                send_byte(CH_SEMI);
            r = $urandom_range(0, 15);
            if (i == 0 && $urandom_range(0, 7) == 0)
                r = 0;
            if (r == 0)
                ;   // empty argument
            else if (r == 1)
                send_decimal($urandom, $urandom_range(0, 1));   // saturates
            else if (fin == CH_SGR && r < 13)
                send_decimal(pick_sgr(), ($urandom_range(0, 9) == 0));
            else if (r < 5)
                send_decimal($urandom_range(0, ARG_LIMIT), 0);
            else if (r == 5)
                send_decimal(ARG_LIMIT + $urandom_range(0, 1), 0);
            else
                send_decimal($urandom_range(0, 40), ($urandom_range(0, 7) == 0));
        end
        send_byte(fin);
    endtask

    // Mostly well-formed sequences; the rest text, dropped escapes, noise.
    task automatic send_random_chunk();
        logic [CHAR_W-1:0] c;
        int                kind;
        int                n;
        kind = $urandom_range(0, 99);
        if (kind < 55)
            send_random_csi(1'b1);
        else if (kind < 75)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                c = CHAR_W'($urandom_range(0, 255));
                send_byte((c == CH_ESC) ? ~c : c);
            end
        end
        else if (kind < 85)
            send_random_csi(1'b0);
        else if (kind < 92)
        begin
            c = CHAR_W'($urandom_range(0, 255));
            send_byte(CH_ESC);
            send_byte((c == CH_LBR) ? ~c : c);
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random_bytes(input int count);
        int start;
        start = sent_bytes;
        while (sent_bytes - start < count)
            send_random_chunk();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Printable extremes right after reset: checks reset colors too.
    task automatic test_plain_text();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_text("Az");
    endtask

    task automatic test_cursor_and_erase();
        send_seq("A");           // default count
        send_seq("0B");          // zero means one
        send_seq("65535C");
        send_seq("7D");
        send_seq("99999A");      // saturates
        send_seq("H");
        send_seq(";5f");         // leading separator: empty row
        send_seq("12;34H");
        send_seq("0;0H");
        send_seq("J");
        send_seq("2K");
        send_seq("65535J");
    endtask

    task automatic test_color_lists();
        send_seq("m");                           // empty list resets
        send_seq("31m");
        send_seq("1;31m");                       // bold picks bright palette
        send_seq("32m");                         // bold sticks
        send_seq("0m");
        send_seq("1;42;93;104m");
        send_seq("39;49m");
        send_seq("38;50;108m");                  // unknown codes skipped
        send_seq("31;32;33;34;35;36;37;44;4m");  // eighth ';' dropped, 44 and 4 merge
    endtask

    task automatic test_dropped_sequences();
        send_byte(CH_ESC);
        send_text("X");          // unknown escape
        send_byte(CH_ESC);
        send_byte(CH_ESC);       // escape after escape is dropped too
        send_text("q");
        send_seq("5Z");          // unknown final
        send_seq("12");
        send_byte(CH_ESC);       // ESC ends the sequence silently
        send_text("r");
        send_seq("3");
        send_byte(8'hFF);
    endtask

    task automatic test_register_writes();
        write_defaults('0, '1, 1'b1);
        send_text("a");          // writes leave current colors alone
        send_seq("m");
        send_seq("31;39;41;49m");
        write_defaults('1, '0, 1'b1);
        send_text("b");
        send_seq("0m");
    endtask

    task automatic test_random_streams();
        int ph;
        for (ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
                write_defaults(pick_rgb(), pick_rgb(), ph == 2);
            run_random_bytes(240);
        end
    endtask

    // Final stretch: no gaps, console always ready.
    task automatic test_unbroken_stream();
        write_defaults(pick_rgb(), pick_rgb(), 1'b0);
        idle_on = 1'b0;
        run_random_bytes(170);
    endtask

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.char_in <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.wdata    <= '0;
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_plain_text();
        test_cursor_and_erase();
        test_color_lists();
        test_dropped_sequences();
        test_register_writes();
        test_random_streams();
        test_unbroken_stream();
        wait_idle();

        $display("Sent %0d bytes, checked %0d commands, made %0d register writes.",
                 sent_bytes, checked_count, reg_writes);
        $display("Covered all finals, SGR palettes, dropped escapes and saturated args.");
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
